// ===== sv/rsf_pkg.sv =====
package rsf_pkg;

  // Sphere table size and derived index widths
  localparam int MAX_SPHERES = 64;
  localparam int SPH_AW      = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

  // Iterative unit lengths, one digit per cycle
  localparam int SQRT_ITERS = 36;
  localparam int DIV_ITERS  = 48;
  localparam int IT_W       = 6;

  // Fixed-point constants (Q16.16)
  localparam logic [30:0] DIST_MAX   = 31'h7FFF_FFFF;
  localparam int          EPS_Q16    = 655;
  localparam logic [30:0] RADIUS_RST = 31'd65536;

  // Configuration register indexes
  localparam logic CFG_SPHERE_COUNT = 1'b0;
  localparam logic CFG_RADIUS_TERM  = 1'b1;

  // Material codes
  localparam logic [1:0] MAT_SKY    = 2'd0;
  localparam logic [1:0] MAT_FLOOR  = 2'd1;
  localparam logic [1:0] MAT_MIRROR = 2'd2;

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,
    OP_TRACE_INIT,
    OP_FLOOR_START,
    OP_DIV_STEP,
    OP_FLOOR_TAKE,
    OP_P_CALC,
    OP_ACC_B,
    OP_ACC_PP,
    OP_B_FLOOR,
    OP_BB_HH,
    OP_BB_HL,
    OP_BB_LL,
    OP_Q_CALC,
    OP_SQRT_Q,
    OP_SQRT_SUM,
    OP_SQRT_STEP,
    OP_S_CALC,
    OP_WIN,
    OP_V,
    OP_NSHIFT,
    OP_ACC_SUM,
    OP_NDIV_START,
    OP_N_TAKE
  } op_t;

  // Multiplier operand selection
  typedef enum logic [2:0] {
    M_NONE,
    M_PD,
    M_PP,
    M_HH,
    M_HL,
    M_LL,
    M_DS,
    M_AA
  } mul_t;

  typedef struct packed {
    op_t               op;
    mul_t              mul;
    logic [1:0]        idx;
    logic [SPH_AW-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic dz_zero;
    logic q_pos;
    logic s_win;
  } sts_t;

endpackage

// ===== sv/rsf_ram.sv =====
module rsf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/rsf_dp.sv =====
module rsf_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rsf_pkg::cmd_t      cmd,
  output rsf_pkg::sts_t      sts,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_sphere_x,
  input  logic signed [31:0] in_sphere_y,
  input  logic signed [31:0] in_sphere_z,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  output logic [1:0]         out_material,
  output logic [30:0]        out_hit_distance,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z
);
  import rsf_pkg::*;

  // Ray and sphere working registers
  logic signed [31:0] o_r [3];
  logic signed [17:0] d_r [3];
  logic signed [32:0] p_r [3];
  logic signed [65:0] prod_r;
  logic signed [50:0] accb_r;
  logic [49:0]        pp_r;
  logic signed [34:0] b_r;
  logic [51:0]        bb_r;
  logic signed [53:0] q_r;
  logic signed [36:0] s_r;
  logic signed [34:0] v_r [3];
  logic [29:0]        a_r [3];
  logic [61:0]        sum_r;
  logic [30:0]        rt_r;

  // Square root unit
  logic [71:0] rad_r;
  logic [37:0] srem_r;
  logic [35:0] root_r;

  // Divider unit; quotient shifts into dnum_r
  logic [47:0] dnum_r;
  logic [31:0] drem_r;
  logic [31:0] dden_r;
  logic        fneg_r;

  // Closest hit so far
  logic [1:0]         mat_r;
  logic [30:0]        dist_r;
  logic signed [17:0] n_r [3];

  // Sphere table
  logic [95:0]       ram_rdata;
  logic              ram_we;
  logic signed [31:0] c_x, c_y, c_z;

  assign ram_we = (cmd.op == OP_LOAD) && (32'(in_entry_index) < MAX_SPHERES);

  rsf_ram #(.WIDTH(96), .DEPTH(MAX_SPHERES)) u_tab (
    .clk   (clk),
    .we    (ram_we),
    .waddr (SPH_AW'(in_entry_index)),
    .wdata ({in_sphere_x, in_sphere_y, in_sphere_z}),
    .raddr (cmd.k),
    .rdata (ram_rdata)
  );

  assign c_x = ram_rdata[95:64];
  assign c_y = ram_rdata[63:32];
  assign c_z = ram_rdata[31:0];

  // Magnitudes and operand pieces
  logic [32:0] pm_i;
  logic [33:0] bm;
  logic [17:0] bh;
  logic [15:0] bl;
  logic signed [32:0] mul_a, mul_b;

  always_comb begin
    pm_i = p_r[cmd.idx][32] ? 33'(-p_r[cmd.idx]) : 33'(p_r[cmd.idx]);
    bm   = b_r[34] ? 34'(-b_r) : 34'(b_r);
    bh   = bm[33:16];
    bl   = bm[15:0];
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul)
      M_PD: begin
        mul_a = p_r[cmd.idx];
        mul_b = 33'(d_r[cmd.idx]);
      end
      M_PP: begin
        mul_a = {1'b0, pm_i[31:0]};
        mul_b = {1'b0, pm_i[31:0]};
      end
      M_HH: begin
        mul_a = {15'b0, bh};
        mul_b = {15'b0, bh};
      end
      M_HL: begin
        mul_a = {15'b0, bh};
        mul_b = {17'b0, bl};
      end
      M_LL: begin
        mul_a = {17'b0, bl};
        mul_b = {17'b0, bl};
      end
      M_DS: begin
        mul_a = 33'(d_r[cmd.idx]);
        mul_b = s_r[32:0];
      end
      M_AA: begin
        mul_a = {3'b0, a_r[cmd.idx]};
        mul_b = {3'b0, a_r[cmd.idx]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Digit step of the square root
  logic [39:0] sq_t, sq_trial;
  logic        sq_ge;
  always_comb begin
    sq_t     = {srem_r, rad_r[71:70]};
    sq_trial = {2'b0, root_r, 2'b01};
    sq_ge    = sq_t >= sq_trial;
  end

  // Bit step of the divider
  logic [32:0] dv_t;
  logic        dv_ge;
  always_comb begin
    dv_t  = {drem_r, dnum_r[47]};
    dv_ge = dv_t >= {1'b0, dden_r};
  end

  // Floor operands
  logic [31:0] oz_mag;
  logic [16:0] dz_mag;
  always_comb begin
    oz_mag = o_r[2][31] ? 32'(-{o_r[2][31], o_r[2]}) : 32'(o_r[2]);
    dz_mag = d_r[2][17] ? 17'(-d_r[2]) : 17'(d_r[2]);
  end

  // Normal scaling: smallest shift bringing all magnitudes below 2^30
  logic [33:0] vm [3];
  logic [33:0] vmx;
  logic [2:0]  vsh;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vm[i] = v_r[i][34] ? 34'(-v_r[i]) : 34'(v_r[i]);
    end
    vmx = vm[0];
    if (vm[1] > vmx) vmx = vm[1];
    if (vm[2] > vmx) vmx = vm[2];
    priority if (vmx[33]) vsh = 3'd4;
    else if (vmx[32])     vsh = 3'd3;
    else if (vmx[31])     vsh = 3'd2;
    else if (vmx[30])     vsh = 3'd1;
    else                  vsh = 3'd0;
  end

  // Normal component from the quotient
  logic signed [17:0] n_val;
  always_comb begin
    if (root_r == '0) begin
      n_val = '0;
    end else if (v_r[cmd.idx][34]) begin
      n_val = -$signed({1'b0, dnum_r[16:0]});
    end else begin
      n_val = $signed({1'b0, dnum_r[16:0]});
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rt_r <= RADIUS_RST;
    end else if (cfg_we && cfg_index == CFG_RADIUS_TERM) begin
      rt_r <= cfg_wdata;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (cmd.op)
      OP_TRACE_INIT: begin
        o_r[0] <= in_origin_x;
        o_r[1] <= in_origin_y;
        o_r[2] <= in_origin_z;
        d_r[0] <= in_dir_x;
        d_r[1] <= in_dir_y;
        d_r[2] <= in_dir_z;
        mat_r  <= MAT_SKY;
        dist_r <= DIST_MAX;
        for (int i = 0; i < 3; i++) begin
          n_r[i] <= '0;
        end
      end
      OP_FLOOR_START: begin
        dnum_r <= {oz_mag, 16'b0};
        dden_r <= {15'b0, dz_mag};
        drem_r <= '0;
        fneg_r <= ((o_r[2] > 0) != d_r[2][17]);
      end
      OP_NDIV_START: begin
        dnum_r <= {2'b0, a_r[cmd.idx], 16'b0};
        dden_r <= root_r[31:0];
        drem_r <= '0;
      end
      OP_DIV_STEP: begin
        if (dv_ge) begin
          drem_r <= 32'(dv_t - {1'b0, dden_r});
          dnum_r <= {dnum_r[46:0], 1'b1};
        end else begin
          drem_r <= dv_t[31:0];
          dnum_r <= {dnum_r[46:0], 1'b0};
        end
      end
      OP_FLOOR_TAKE: begin
        if (!fneg_r && dnum_r > 48'(EPS_Q16)) begin
          dist_r <= (dnum_r > 48'(DIST_MAX)) ? DIST_MAX : dnum_r[30:0];
          mat_r  <= MAT_FLOOR;
          n_r[0] <= '0;
          n_r[1] <= '0;
          n_r[2] <= 18'sd65536;
        end
      end
      OP_P_CALC: begin
        p_r[0] <= 33'(o_r[0]) - 33'(c_x);
        p_r[1] <= 33'(o_r[1]) - 33'(c_y);
        p_r[2] <= 33'(o_r[2]) - 33'(c_z);
        accb_r <= '0;
        pp_r   <= '0;
      end
      OP_ACC_B:   accb_r <= accb_r + $signed(prod_r[50:0]);
      OP_ACC_PP:  pp_r   <= pp_r + {2'b0, prod_r[63:16]};
      OP_B_FLOOR: b_r    <= accb_r[50:16];
      OP_BB_HH:   bb_r   <= {prod_r[35:0], 16'b0};
      OP_BB_HL:   bb_r   <= bb_r + {17'b0, prod_r[33:0], 1'b0};
      OP_BB_LL:   bb_r   <= bb_r + {36'b0, prod_r[31:16]};
      OP_Q_CALC: begin
        q_r <= $signed({2'b0, bb_r}) - $signed({4'b0, pp_r}) + $signed({23'b0, rt_r});
      end
      OP_SQRT_Q: begin
        rad_r  <= {4'b0, q_r[51:0], 16'b0};
        srem_r <= '0;
        root_r <= '0;
      end
      OP_SQRT_SUM: begin
        rad_r  <= {10'b0, sum_r};
        srem_r <= '0;
        root_r <= '0;
      end
      OP_SQRT_STEP: begin
        rad_r <= {rad_r[69:0], 2'b00};
        if (sq_ge) begin
          srem_r <= 38'(sq_t - sq_trial);
          root_r <= {root_r[34:0], 1'b1};
        end else begin
          srem_r <= sq_t[37:0];
          root_r <= {root_r[34:0], 1'b0};
        end
      end
      OP_S_CALC: s_r <= -37'(b_r) - $signed({2'b0, root_r[34:0]});
      OP_WIN: begin
        dist_r <= s_r[30:0];
        mat_r  <= MAT_MIRROR;
      end
      OP_V: v_r[cmd.idx] <= 35'(p_r[cmd.idx]) + 35'($signed(prod_r[47:16]));
      OP_NSHIFT: begin
        for (int i = 0; i < 3; i++) begin
          a_r[i] <= 30'(vm[i] >> vsh);
        end
        sum_r <= '0;
      end
      OP_ACC_SUM: sum_r <= sum_r + prod_r[61:0];
      OP_N_TAKE:  n_r[cmd.idx] <= n_val;
      default: begin
      end
    endcase
  end

  // Status to the controller
  assign sts.dz_zero = (d_r[2] == '0);
  assign sts.q_pos   = (q_r > 0);
  assign sts.s_win   = (s_r > 37'sd655) && (s_r < $signed({6'b0, dist_r}));

  assign out_material     = mat_r;
  assign out_hit_distance = dist_r;
  assign out_normal_x     = n_r[0];
  assign out_normal_y     = n_r[1];
  assign out_normal_z     = n_r[2];

endmodule

// ===== sv/rsf_ctrl.sv =====
module rsf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_req_type,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [6:0]    cfg_count,
  input  rsf_pkg::sts_t sts,
  output rsf_pkg::cmd_t cmd,
  output logic          busy,
  output logic          out_valid
);
  import rsf_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE, S_FLOOR_CHK, S_FLOOR_DIV, S_FLOOR_TAKE, S_LOOP,
    S_SPH_RD, S_SPH_P, S_DOT_MUL, S_DOT_ACC, S_PP_MUL, S_PP_ACC,
    S_B_FLOOR, S_HH_MUL, S_HH_ACC, S_HL_MUL, S_HL_ACC, S_LL_MUL, S_LL_ACC,
    S_Q_CALC, S_Q_CHK, S_SQ1, S_S_CALC, S_S_CHK, S_V_MUL, S_V_ACC,
    S_NSHIFT, S_A_MUL, S_A_ACC, S_SQ2_GO, S_SQ2, S_N_START, S_N_DIV, S_N_TAKE
  } state_t;

  state_t           state_r;
  logic             busy_r;
  logic             out_valid_r;
  logic [CNT_W-1:0] k_r;
  logic [1:0]       idx_r;
  logic [IT_W-1:0]  it_r;
  logic [6:0]       count_r;

  logic [CNT_W-1:0] lim;
  logic             last_k;
  logic             sqrt_last, div_last;

  assign lim = (32'(count_r) > MAX_SPHERES) ? CNT_W'(MAX_SPHERES) : CNT_W'(count_r);
  assign last_k    = (k_r + 1'b1) >= lim;
  assign sqrt_last = (it_r == IT_W'(SQRT_ITERS - 1));
  assign div_last  = (it_r == IT_W'(DIV_ITERS - 1));

  // Command decode
  always_comb begin
    cmd.op  = OP_NOP;
    cmd.mul = M_NONE;
    cmd.idx = idx_r;
    cmd.k   = k_r[SPH_AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) cmd.op = in_req_type ? OP_TRACE_INIT : OP_LOAD;
      end
      S_FLOOR_CHK:  if (!sts.dz_zero) cmd.op = OP_FLOOR_START;
      S_FLOOR_DIV:  cmd.op = OP_DIV_STEP;
      S_FLOOR_TAKE: cmd.op = OP_FLOOR_TAKE;
      S_SPH_P:      cmd.op = OP_P_CALC;
      S_DOT_MUL:    cmd.mul = M_PD;
      S_DOT_ACC:    cmd.op = OP_ACC_B;
      S_PP_MUL:     cmd.mul = M_PP;
      S_PP_ACC:     cmd.op = OP_ACC_PP;
      S_B_FLOOR:    cmd.op = OP_B_FLOOR;
      S_HH_MUL:     cmd.mul = M_HH;
      S_HH_ACC:     cmd.op = OP_BB_HH;
      S_HL_MUL:     cmd.mul = M_HL;
      S_HL_ACC:     cmd.op = OP_BB_HL;
      S_LL_MUL:     cmd.mul = M_LL;
      S_LL_ACC:     cmd.op = OP_BB_LL;
      S_Q_CALC:     cmd.op = OP_Q_CALC;
      S_Q_CHK:      if (sts.q_pos) cmd.op = OP_SQRT_Q;
      S_SQ1:        cmd.op = OP_SQRT_STEP;
      S_S_CALC:     cmd.op = OP_S_CALC;
      S_S_CHK:      if (sts.s_win) cmd.op = OP_WIN;
      S_V_MUL:      cmd.mul = M_DS;
      S_V_ACC:      cmd.op = OP_V;
      S_NSHIFT:     cmd.op = OP_NSHIFT;
      S_A_MUL:      cmd.mul = M_AA;
      S_A_ACC:      cmd.op = OP_ACC_SUM;
      S_SQ2_GO:     cmd.op = OP_SQRT_SUM;
      S_SQ2:        cmd.op = OP_SQRT_STEP;
      S_N_START:    cmd.op = OP_NDIV_START;
      S_N_DIV:      cmd.op = OP_DIV_STEP;
      S_N_TAKE:     cmd.op = OP_N_TAKE;
      default:      cmd.op = OP_NOP;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      idx_r       <= '0;
      it_r        <= '0;
      count_r     <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we && cfg_index == CFG_SPHERE_COUNT) begin
        count_r <= cfg_count;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start && in_req_type) begin
            busy_r  <= 1'b1;
            state_r <= S_FLOOR_CHK;
          end
        end
        S_FLOOR_CHK: begin
          it_r    <= '0;
          state_r <= sts.dz_zero ? S_LOOP : S_FLOOR_DIV;
        end
        S_FLOOR_DIV: begin
          it_r <= it_r + 1'b1;
          if (div_last) state_r <= S_FLOOR_TAKE;
        end
        S_FLOOR_TAKE: state_r <= S_LOOP;
        S_LOOP: begin
          k_r <= '0;
          if (lim == '0) begin
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_SPH_RD;
          end
        end
        S_SPH_RD: state_r <= S_SPH_P;
        S_SPH_P: begin
          idx_r   <= '0;
          state_r <= S_DOT_MUL;
        end
        S_DOT_MUL: state_r <= S_DOT_ACC;
        S_DOT_ACC: begin
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_PP_MUL;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_DOT_MUL;
          end
        end
        S_PP_MUL: state_r <= S_PP_ACC;
        S_PP_ACC: begin
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_B_FLOOR;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_PP_MUL;
          end
        end
        S_B_FLOOR: state_r <= S_HH_MUL;
        S_HH_MUL:  state_r <= S_HH_ACC;
        S_HH_ACC:  state_r <= S_HL_MUL;
        S_HL_MUL:  state_r <= S_HL_ACC;
        S_HL_ACC:  state_r <= S_LL_MUL;
        S_LL_MUL:  state_r <= S_LL_ACC;
        S_LL_ACC:  state_r <= S_Q_CALC;
        S_Q_CALC:  state_r <= S_Q_CHK;
        S_Q_CHK: begin
          it_r <= '0;
          if (sts.q_pos) begin
            state_r <= S_SQ1;
          end else if (last_k) begin
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SPH_RD;
          end
        end
        S_SQ1: begin
          it_r <= it_r + 1'b1;
          if (sqrt_last) state_r <= S_S_CALC;
        end
        S_S_CALC: state_r <= S_S_CHK;
        S_S_CHK: begin
          idx_r <= '0;
          if (sts.s_win) begin
            state_r <= S_V_MUL;
          end else if (last_k) begin
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SPH_RD;
          end
        end
        S_V_MUL: state_r <= S_V_ACC;
        S_V_ACC: begin
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_NSHIFT;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_V_MUL;
          end
        end
        S_NSHIFT: state_r <= S_A_MUL;
        S_A_MUL:  state_r <= S_A_ACC;
        S_A_ACC: begin
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            state_r <= S_SQ2_GO;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_A_MUL;
          end
        end
        S_SQ2_GO: begin
          it_r    <= '0;
          state_r <= S_SQ2;
        end
        S_SQ2: begin
          it_r <= it_r + 1'b1;
          if (sqrt_last) state_r <= S_N_START;
        end
        S_N_START: begin
          it_r    <= '0;
          state_r <= S_N_DIV;
        end
        S_N_DIV: begin
          it_r <= it_r + 1'b1;
          if (div_last) state_r <= S_N_TAKE;
        end
        S_N_TAKE: begin
          if (idx_r != 2'd2) begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_N_START;
          end else if (last_k) begin
            busy_r      <= 1'b0;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= S_SPH_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

// ===== sv/ray_sphere_floor_closest_hit.sv =====
// Closest-hit caster for a floor plane and a table of mirror spheres in Q16.16.
// A load (start with in_req_type low, busy low) writes one sphere centre and is
// done at once: busy does not rise and no result follows. A trace raises busy
// for the whole walk and ends with one result, shown for exactly one cycle
// with out_valid high just as busy falls; the receiver cannot stall, so it must
// take the result in that cycle. A trace runs the floor divide (skipped when
// dir_z is zero), then tests each sphere in use; a miss or a hit that is not
// nearer ends that sphere's test, and a new nearest hit goes on to the
// normal, using the 36-step square root unit and the 48-step divider. The
// user must write configuration only while busy is low and no result is
// pending; the block itself does not enforce this.
module ray_sphere_floor_closest_hit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_sphere_x,
  input  logic signed [31:0] in_sphere_y,
  input  logic signed [31:0] in_sphere_z,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  output logic               out_valid,
  output logic [1:0]         out_material,
  output logic [30:0]        out_hit_distance,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata
);
  import rsf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  rsf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_req_type (in_req_type),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_count   (cfg_wdata[6:0]),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (busy),
    .out_valid   (out_valid)
  );

  // Arithmetic, sphere table and result registers
  rsf_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_entry_index   (in_entry_index),
    .in_sphere_x      (in_sphere_x),
    .in_sphere_y      (in_sphere_y),
    .in_sphere_z      (in_sphere_z),
    .in_origin_x      (in_origin_x),
    .in_origin_y      (in_origin_y),
    .in_origin_z      (in_origin_z),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .out_material     (out_material),
    .out_hit_distance (out_hit_distance),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z)
  );

`ifndef NO_ASSERTIONS
  // A result is never shown while a trace is still running
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // Every finished trace gives its result in the cycle busy drops
  a_fall_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("trace ended without result");

  // A load transfer gives no result
  a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req_type) |=> !out_valid)
    else $error("result after load");

  // A sky result carries the largest distance
  a_sky_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_material == MAT_SKY) |-> out_hit_distance == DIST_MAX)
    else $error("sky result with finite distance");
`endif

endmodule

// ===== dv/rsf_hit_checker.sv =====
`timescale 1ns / 1ps

// Watches the ray caster's channels, predicts every trace result and
// compares each result transfer against the oldest prediction.
module rsf_hit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_req_type,
  input  logic [5:0]         in_entry_index,
  input  logic signed [31:0] in_sphere_x,
  input  logic signed [31:0] in_sphere_y,
  input  logic signed [31:0] in_sphere_z,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  input  logic               out_valid,
  input  logic [1:0]         out_material,
  input  logic [30:0]        out_hit_distance,
  input  logic signed [17:0] out_normal_x,
  input  logic signed [17:0] out_normal_y,
  input  logic signed [17:0] out_normal_z,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [30:0]        cfg_wdata,
  output int                 fail_count,
  output int                 open_rays
);
  import rsf_pkg::*;

  typedef struct packed {
    logic [1:0]         material;
    logic [30:0]        hit_dist;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
  } hit_t;

  localparam longint DMAX = 64'h7FFF_FFFF;

  // Shadow state of the block
  logic [6:0]  sph_count;
  logic [30:0] radius_sq;
  longint      centre [MAX_SPHERES][3];
  hit_t        pending_hits[$];

  // floor(sqrt(x * 4^extra)), one digit pair per pass
  function automatic longint unsigned isqrt(longint unsigned x, int extra);
    longint unsigned rem, root, trial, pair;
    rem = 0;
    root = 0;
    for (int i = 31 + extra; i >= 0; i--) begin
      pair = (i >= extra) ? ((x >> (2 * (i - extra))) & 64'd3) : 64'd0;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem -= trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // Closest hit over floor and the spheres in use
  function automatic hit_t cast_ray(longint ox, longint oy, longint oz,
                                    longint dx, longint dy, longint dz);
    hit_t            r;
    longint          o[3], d[3], p[3], v[3], nrm[3];
    longint          best_dist, t, b, q, s;
    longint unsigned m, pp, bm, h, l, bb, a[3], mx, sum, len;
    int              cnt, sh;
    o = '{ox, oy, oz};
    d = '{dx, dy, dz};
    nrm = '{0, 0, 0};
    best_dist = DMAX;
    r.material = MAT_SKY;
    // floor plane z = 0; a zero dz never reaches it
    if (dz != 0) begin
      t = (-oz * 65536) / dz;
      if (t > EPS_Q16) begin
        best_dist = (t > DMAX) ? DMAX : t;
        nrm = '{0, 0, 65536};
        r.material = MAT_FLOOR;
      end
    end
    cnt = (sph_count > MAX_SPHERES) ? MAX_SPHERES : int'(sph_count);
    for (int k = 0; k < cnt; k++) begin
      for (int i = 0; i < 3; i++) p[i] = o[i] - centre[k][i];
      b = (p[0] * d[0] + p[1] * d[1] + p[2] * d[2]) >>> 16;
      pp = 0;
      for (int i = 0; i < 3; i++) begin
        m = (p[i] < 0) ? -p[i] : p[i];
        pp += (m * m) >> 16;
      end
      bm = (b < 0) ? -b : b;
      h = bm >> 16;
      l = bm & 64'hFFFF;
      bb = ((h * h) << 16) + 2 * h * l + ((l * l) >> 16);
      q = longint'(bb) - longint'(pp) + longint'(radius_sq);
      if (q <= 0) continue;
      s = -b - longint'(isqrt(q, 8));
      // ties and far roots keep the earlier hit
      if (s < best_dist && s > EPS_Q16) begin
        best_dist = s;
        r.material = MAT_MIRROR;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
          v[i] = p[i] + ((d[i] * s) >>> 16);
          a[i] = (v[i] < 0) ? -v[i] : v[i];
          if (a[i] > mx) mx = a[i];
        end
        sh = 0;
        while (mx >= (64'd1 << 30)) begin
          mx = mx >> 1;
          sh++;
        end
        sum = 0;
        for (int i = 0; i < 3; i++) begin
          a[i] = a[i] >> sh;
          sum += a[i] * a[i];
        end
        len = isqrt(sum, 0);
        for (int i = 0; i < 3; i++) begin
          nrm[i] = (len != 0) ? longint'((a[i] << 16) / len) : 0;
          if (v[i] < 0) nrm[i] = -nrm[i];
        end
      end
    end
    r.hit_dist = best_dist[30:0];
    r.nx = nrm[0][17:0];
    r.ny = nrm[1][17:0];
    r.nz = nrm[2][17:0];
    return r;
  endfunction

  always @(posedge clk) begin
    hit_t want;
    if (!rst_n) begin
      sph_count = '0;
      radius_sq = RADIUS_RST;
      fail_count = 0;
      pending_hits.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == CFG_SPHERE_COUNT) sph_count = cfg_wdata[6:0];
        else radius_sq = cfg_wdata;
      end
      // result transfer
      if (out_valid) begin
        if (pending_hits.size() == 0) begin
          $error("result transfer with no trace outstanding");
          fail_count++;
        end else begin
          want = pending_hits.pop_front();
          if (out_material !== want.material) begin
            $error("material: expected %0d, got %0d", want.material, out_material);
            fail_count++;
          end
          if (out_hit_distance !== want.hit_dist) begin
            $error("hit_distance: expected %0d, got %0d", want.hit_dist, out_hit_distance);
            fail_count++;
          end
          if (out_normal_x !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, out_normal_x);
            fail_count++;
          end
          if (out_normal_y !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, out_normal_y);
            fail_count++;
          end
          if (out_normal_z !== want.nz) begin
            $error("normal_z: expected %0d, got %0d", want.nz, out_normal_z);
            fail_count++;
          end
        end
      end
      // input transfer
      if (start && !busy) begin
        if (!in_req_type) begin
          centre[in_entry_index][0] = in_sphere_x;
          centre[in_entry_index][1] = in_sphere_y;
          centre[in_entry_index][2] = in_sphere_z;
        end else begin
          pending_hits.push_back(cast_ray(in_origin_x, in_origin_y, in_origin_z,
                                          in_dir_x, in_dir_y, in_dir_z));
        end
      end
    end
    open_rays = pending_hits.size();
  end

endmodule

// ===== dv/ray_sphere_floor_closest_hit_tb.sv =====
`timescale 1ns / 1ps

module ray_sphere_floor_closest_hit_tb;
  import rsf_pkg::*;

  localparam int U = 65536;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_req_type;
  logic [5:0]         in_entry_index;
  logic signed [31:0] in_sphere_x, in_sphere_y, in_sphere_z;
  logic signed [31:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [17:0] in_dir_x, in_dir_y, in_dir_z;
  logic               out_valid;
  logic [1:0]         out_material;
  logic [30:0]        out_hit_distance;
  logic signed [17:0] out_normal_x, out_normal_y, out_normal_z;
  logic               cfg_we;
  logic               cfg_index;
  logic [30:0]        cfg_wdata;
  int                 fail_count;
  int                 open_rays;

  int scene [64][3];
  int idle_pct;
  int live_count;

  ray_sphere_floor_closest_hit u_top (.*);

  rsf_hit_checker u_chk (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial begin
    #300000000;
    $display("ray_sphere_floor_closest_hit verification failed");
    $finish;
  end

  // One input transfer; then, idle_pct percent of the time, a random gap
  task automatic issue(logic req, logic [5:0] idx, int sx, int sy, int sz,
                       int ox, int oy, int oz, int dx, int dy, int dz);
    in_req_type <= req;
    in_entry_index <= idx;
    in_sphere_x <= sx;
    in_sphere_y <= sy;
    in_sphere_z <= sz;
    in_origin_x <= ox;
    in_origin_y <= oy;
    in_origin_z <= oz;
    in_dir_x <= dx;
    in_dir_y <= dy;
    in_dir_z <= dz;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic load_slot(int idx, int x, int y, int z);
    scene[idx] = '{x, y, z};
    issue(1'b0, idx[5:0], x, y, z, $urandom, $urandom, $urandom,
          $urandom_range(0, 131072) - U, $urandom_range(0, 131072) - U,
          $urandom_range(0, 131072) - U);
  endtask

  task automatic cast(int ox, int oy, int oz, int dx, int dy, int dz);
    issue(1'b1, 6'($urandom), $urandom, $urandom, $urandom, ox, oy, oz, dx, dy, dz);
  endtask

  // Hold input off until the block is idle and every trace has answered
  task automatic settle();
    start <= 1'b0;
    @(negedge clk);
    while (busy || open_rays > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_reg(logic idx, int unsigned val);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[30:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SPHERE_COUNT) live_count = (val > 64) ? 64 : val;
  endtask

  task automatic scene_sphere(int idx);
    if ($urandom_range(7) == 0)
      load_slot(idx, int'($urandom) >>> 1, int'($urandom) >>> 1, int'($urandom) >>> 1);
    else
      load_slot(idx, int'($urandom_range(0, 16 * U)) - 8 * U,
                int'($urandom_range(0, 16 * U)) - 8 * U, int'($urandom_range(0, 6 * U)));
  endtask

  int   ph_cnt [7] = '{8, 16, 64, 127, 3, 0, 12};
  int   ph_rad [7] = '{65536, 262144, 16384, 0, 32'h7FFF_FFFF, 65536, 131072};
  int   ph_idle[7] = '{0, 73, 24, 73, 0, 24, 73};
  int   ph_len [7] = '{48, 48, 16, 16, 24, 16, 40};

  initial begin
    int     k, ox, oy, oz, pick, guard;
    longint vx, vy, vz;
    real    len;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_SPHERE_COUNT;
    cfg_wdata = '0;
    in_req_type = 1'b0;
    in_entry_index = '0;
    {in_sphere_x, in_sphere_y, in_sphere_z} = '0;
    {in_origin_x, in_origin_y, in_origin_z} = '0;
    {in_dir_x, in_dir_y, in_dir_z} = '0;
    idle_pct = 0;
    live_count = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Floor-only rays: plain hit, flat ray, saturated distance, threshold
    cast(0, 0, 5 * U, 0, 0, -U);
    cast(0, 0, 5 * U, U, 0, 0);
    cast(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 1);
    cast(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, -U);
    cast(0, 0, -655, 0, 0, U);
    cast(0, 0, -656, 0, 0, U);
    cast(U, U, U, U, U, U);
    cast(-U, -U, -U, -U, -U, -U);

    // Extreme centres, later overwritten; then a small scene
    load_slot(63, 32'h7FFF_FFFF, 32'h8000_0000, 0);
    load_slot(63, 32'h8000_0000, 32'h7FFF_FFFF, -1);
    load_slot(0, 0, 0, 3 * U);
    load_slot(1, 0, 0, 3 * U);
    load_slot(2, 0, 0, -20 * U);
    set_reg(CFG_SPHERE_COUNT, 3);
    // near sphere wins, equal twin ignored, sphere under floor ignored
    cast(0, 0, 8 * U, 0, 0, -U);
    // origin under the floor: only the low sphere is ahead
    cast(0, 0, -10 * U, 0, 0, -U);
    // grazing and clean misses
    cast(U, 0, 8 * U, 0, 0, -U);
    cast(5 * U, 5 * U, 8 * U, 0, 0, -U);
    cast(0, 0, 8 * U, 0, U, 0);

    // Fill the whole table before any wide trace
    for (int i = 0; i < 64; i++) scene_sphere(i);

    for (int ph = 0; ph < 7; ph++) begin
      set_reg(CFG_SPHERE_COUNT, ph_cnt[ph]);
      set_reg(CFG_RADIUS_TERM, ph_rad[ph]);
      idle_pct = ph_idle[ph];
      for (int n = 0; n < ph_len[ph]; n++) begin
        if (n == ph_len[ph] / 2) settle();
        pick = $urandom_range(99);
        if (pick < 12) begin
          scene_sphere($urandom_range(63));
        end else if (pick < 80) begin
          // ray aimed near a sphere in use, or near any slot when none is in use
          k = (live_count > 0) ? $urandom_range(live_count - 1) : $urandom_range(63);
          ox = int'($urandom_range(0, 32 * U)) - 16 * U;
          oy = int'($urandom_range(0, 32 * U)) - 16 * U;
          oz = int'($urandom_range(0, 16 * U));
          vx = longint'(scene[k][0]) + $urandom_range(0, 98304) - 49152 - ox;
          vy = longint'(scene[k][1]) + $urandom_range(0, 98304) - 49152 - oy;
          vz = longint'(scene[k][2]) + $urandom_range(0, 98304) - 49152 - oz;
          len = $sqrt(real'(vx) * real'(vx) + real'(vy) * real'(vy) + real'(vz) * real'(vz));
          if (len < 1.0)
            cast(ox, oy, oz, 0, 0, -U);
          else
            cast(ox, oy, oz, $rtoi(real'(vx) * U / len), $rtoi(real'(vy) * U / len),
                 $rtoi(real'(vz) * U / len));
        end else begin
          // arbitrary origin and direction
          cast($urandom, $urandom, $urandom, $urandom_range(0, 131072) - U,
               $urandom_range(0, 131072) - U,
               ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 131072) - U);
        end
      end
    end

    // Drain and give the verdict
    start <= 1'b0;
    guard = 0;
    @(negedge clk);
    while ((busy || open_rays > 0) && guard < 200000) begin
      @(negedge clk);
      guard++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && open_rays == 0)
      $display("ray_sphere_floor_closest_hit verification clean");
    else
      $display("ray_sphere_floor_closest_hit verification failed");
    $finish;
  end

endmodule
